// ----- design/ssp_pkg.sv -----
// Shared types and constants for the seven-segment scan and dimming block.
// Holds the transaction payload structs, the opcode codes and the register map.
// No dependencies.
package ssp_pkg;

  localparam logic [2:0] OP_TICK      = 3'd0;
  localparam logic [2:0] OP_WRITE_SEG = 3'd1;
  localparam logic [2:0] OP_LINE_EN   = 3'd2;
  localparam logic [2:0] OP_ALL       = 3'd3;
  localparam logic [2:0] OP_IND_BIT   = 3'd4;

  localparam logic       REG_BRIGHTNESS     = 1'b0;
  localparam logic       REG_INDICATOR_LINE = 1'b1;
  localparam int         PADDR_W            = 3;

  localparam logic [2:0] BRIGHTNESS_RESET = 3'd5;
  localparam int         DRIVE_LINES      = 3;
  localparam int         COL_W            = 4;

  typedef struct packed {
    logic [2:0] opcode;
    logic [1:0] line_index;
    logic [2:0] column_index;
    logic [7:0] segment_value;
    logic       enable;
    logic [2:0] indicator_index;
  } item_t;

  typedef struct packed {
    logic [3:0]  column_select;
    logic [23:0] line_drive;
    logic        frame_start;
    logic [7:0]  indicator_bits;
  } result_t;

  typedef struct packed {
    logic [2:0] brightness;
    logic [1:0] indicator_line;
  } cfg_t;

endpackage

// ----- design/ssp_regs.sv -----
// Configuration register file behind the APB-style port.
// Holds brightness and the indicator line; depends on ssp_pkg.
module ssp_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ssp_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  output ssp_pkg::cfg_t                cfg
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.brightness     <= ssp_pkg::BRIGHTNESS_RESET;
      cfg.indicator_line <= 2'd0;
    end else if (wr_en) begin
      case (paddr[2])
        ssp_pkg::REG_BRIGHTNESS:     cfg.brightness     <= pwdata[2:0];
        ssp_pkg::REG_INDICATOR_LINE: cfg.indicator_line <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      ssp_pkg::REG_BRIGHTNESS:     prdata = {29'd0, cfg.brightness};
      ssp_pkg::REG_INDICATOR_LINE: prdata = {30'd0, cfg.indicator_line};
      default:                     prdata = 32'd0;
    endcase
  end

endmodule

// ----- design/ssp_core.sv -----
// Scan state, segment store and result logic for one transaction.
// Updates state on advance and presents the result for the output register.
// Depends on ssp_pkg.
module ssp_core #(
  parameter int LINES     = 3,
  parameter int COLUMNS   = 8,
  parameter int PWM_STEPS = 5
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  ssp_pkg::item_t   item,
  input  ssp_pkg::cfg_t    cfg,
  output ssp_pkg::result_t result
);

  localparam int PHASE_W   = (PWM_STEPS > 2) ? $clog2(PWM_STEPS) : 1;
  localparam int COL_IDX_W = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam logic [ssp_pkg::COL_W-1:0] COL_IND  = ssp_pkg::COL_W'(COLUMNS);
  localparam logic [ssp_pkg::COL_W-1:0] COL_NONE = ssp_pkg::COL_W'(COLUMNS + 1);

  logic [PHASE_W-1:0]        pwm_phase, pwm_phase_next;
  logic [ssp_pkg::COL_W-1:0] scan_column, scan_column_next;
  logic [LINES-1:0]          line_enables, line_enables_next;
  logic                      indicator_enable, indicator_enable_next;
  logic [7:0]                indicator_register, indicator_register_next;
  logic [ssp_pkg::COL_W-1:0] held_column, held_column_next;
  logic [23:0]               held_drive, held_drive_next;
  logic                      frame;
  logic [23:0]               drive;
  logic [ssp_pkg::COL_W-1:0] mirror;
  logic                      is_tick;
  logic                      col_ok;

  assign is_tick = (item.opcode == ssp_pkg::OP_TICK);
  assign col_ok  = ({1'b0, item.column_index} < ssp_pkg::COL_W'(COLUMNS));
  assign mirror  = ssp_pkg::COL_W'(COLUMNS - 1) - scan_column;

  for (genvar ln = 0; ln < LINES; ln++) begin : g_line
    logic [7:0] col_bytes [COLUMNS];
    logic       wr_hit;

    assign wr_hit = advance && (item.opcode == ssp_pkg::OP_WRITE_SEG) &&
                    (int'(item.line_index) == ln) && col_ok;

    always_ff @(posedge clk) begin
      if (rst) begin
        for (int c = 0; c < COLUMNS; c++) col_bytes[c] <= 8'd0;
      end else if (wr_hit) begin
        col_bytes[COL_IDX_W'(item.column_index)] <= item.segment_value;
      end
    end

    always_comb begin
      line_enables_next[ln] = line_enables[ln];
      case (item.opcode)
        ssp_pkg::OP_LINE_EN: begin
          if (int'(item.line_index) == ln) line_enables_next[ln] = item.enable;
        end
        ssp_pkg::OP_ALL: line_enables_next[ln] = item.enable;
        default: ;
      endcase
    end
  end

  for (genvar ln = 0; ln < ssp_pkg::DRIVE_LINES; ln++) begin : g_drive
    if (ln < LINES) begin : g_on
      always_comb begin
        drive[8*ln +: 8] = 8'd0;
        if (scan_column == COL_IND) begin
          if ((int'(cfg.indicator_line) == ln) && !indicator_enable)
            drive[8*ln +: 8] = indicator_register;
        end else if (scan_column < COL_IND) begin
          if (line_enables[ln])
            drive[8*ln +: 8] = g_line[ln].col_bytes[mirror[COL_IDX_W-1:0]];
        end
      end
    end else begin : g_off
      assign drive[8*ln +: 8] = 8'd0;
    end
  end

  always_comb begin
    pwm_phase_next          = pwm_phase;
    scan_column_next        = scan_column;
    held_column_next        = held_column;
    held_drive_next         = held_drive;
    indicator_enable_next   = indicator_enable;
    indicator_register_next = indicator_register;
    frame                   = 1'b0;
    case (item.opcode)
      ssp_pkg::OP_TICK: begin
        if (pwm_phase == '0) begin
          frame            = (scan_column == '0);
          held_column_next = scan_column;
          held_drive_next  = drive;
          scan_column_next = (scan_column == COL_IND) ? '0 : scan_column + 1'b1;
        end else if (4'(pwm_phase) == {1'b0, cfg.brightness}) begin
          held_drive_next = 24'd0;
        end
        pwm_phase_next = (pwm_phase == PHASE_W'(PWM_STEPS - 1)) ? '0
                                                                : pwm_phase + 1'b1;
      end
      ssp_pkg::OP_ALL: indicator_enable_next = !item.enable;
      ssp_pkg::OP_IND_BIT:
        indicator_register_next[item.indicator_index] = item.enable;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pwm_phase          <= '0;
      scan_column        <= '0;
      line_enables       <= '0;
      indicator_enable   <= 1'b0;
      indicator_register <= 8'd0;
      held_column        <= COL_NONE;
      held_drive         <= 24'd0;
    end else if (advance) begin
      pwm_phase          <= pwm_phase_next;
      scan_column        <= scan_column_next;
      line_enables       <= line_enables_next;
      indicator_enable   <= indicator_enable_next;
      indicator_register <= indicator_register_next;
      held_column        <= held_column_next;
      held_drive         <= held_drive_next;
    end
  end

  assign result.column_select  = held_column_next;
  assign result.line_drive     = held_drive_next;
  assign result.frame_start    = frame & is_tick;
  assign result.indicator_bits = indicator_register_next;

endmodule

// ----- design/seven_segment_scan_pwm_top.sv -----
// Top level of the seven-segment scan and dimming block.
// Input register, output register and the core; depends on ssp_pkg,
// ssp_regs and ssp_core.
//
//   channel   direction  handshake                    payload
//   item      in         item_valid / item_ready      ssp_pkg::item_t
//   result    out        result_valid / result_ready  ssp_pkg::result_t
//   config    in         psel penable pwrite pready   paddr, pwdata, prdata
//
// One transaction per cycle sustained while result_ready keeps the output from
// stalling; after acceptance the input register feeds the core's single pass,
// which is registered in the result register when the output can advance.
// Reset is synchronous: scan, store, enables and indicators clear, no column
// is held. A stalled result holds in the output register while one more
// transaction waits in the input register.
module seven_segment_scan_pwm_top #(
  parameter int LINES     = 3,
  parameter int COLUMNS   = 8,
  parameter int PWM_STEPS = 5
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        item_valid,
  output logic                        item_ready,
  input  ssp_pkg::item_t              item,
  output logic                        result_valid,
  input  logic                        result_ready,
  output ssp_pkg::result_t            result,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ssp_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  ssp_pkg::cfg_t    cfg;
  ssp_pkg::item_t   item_q;
  ssp_pkg::result_t core_result;
  logic             item_q_valid;
  logic             advance;

  assign advance    = item_q_valid && (!result_valid || result_ready);
  assign item_ready = !item_q_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_q_valid <= 1'b0;
    end else if (item_ready) begin
      item_q_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready && item_valid) begin
      item_q <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= core_result;
    end
  end

  ssp_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ssp_core #(
    .LINES     (LINES),
    .COLUMNS   (COLUMNS),
    .PWM_STEPS (PWM_STEPS)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (item_q),
    .cfg     (cfg),
    .result  (core_result)
  );

endmodule

// ----- design/ssp_checker.sv -----
// Port-level checks for the seven-segment scan and dimming block.
// Bound to seven_segment_scan_pwm_top; depends on ssp_pkg.
module ssp_checker #(
  parameter int COLUMNS = 8
) (
  input logic             clk,
  input logic             rst,
  input logic             result_valid,
  input logic             result_ready,
  input ssp_pkg::result_t result
);

  localparam logic [3:0] COL_NONE = 4'(COLUMNS + 1);

  a_frame_col0: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.frame_start |-> result.column_select == 4'd0)
    else $error("frame start away from column 0");

  a_none_dark: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.column_select == COL_NONE |-> result.line_drive == 24'd0)
    else $error("lines driven with no column selected");

  a_col_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.column_select <= COL_NONE)
    else $error("column select out of range");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("stalled result changed");

endmodule

bind seven_segment_scan_pwm_top ssp_checker #(.COLUMNS(COLUMNS)) u_ssp_checker (.*);
